// File: sv/rational_arith_unit_defines.svh
// Assertion helpers used by the top file that checks this block.
`ifndef RATIONAL_ARITH_UNIT_DEFINES_SVH
`define RATIONAL_ARITH_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, idle during reset.
`define RAU_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("rational_arith_unit: check failed");

// Next-cycle implication, sampled on the rising clock, idle during reset.
`define RAU_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("rational_arith_unit: check failed");

`endif

// File: sv/rau_pkg.sv
package rau_pkg;

  localparam int OW        = 16;
  localparam int PW        = 2 * OW;
  localparam int RES_NUM_W = 33;
  localparam int RES_DEN_W = 31;
  localparam int FUNC_W    = 4;
  // The queue pointers wrap by overflow, so the depth stays a power of two.
  localparam int QDEPTH    = 2;
  localparam int QAW       = $clog2(QDEPTH);
  localparam int QCW       = $clog2(QDEPTH + 1);

  localparam logic [FUNC_W-1:0] FN_ADD = 4'd0;
  localparam logic [FUNC_W-1:0] FN_SUB = 4'd1;
  localparam logic [FUNC_W-1:0] FN_MUL = 4'd2;
  localparam logic [FUNC_W-1:0] FN_DIV = 4'd3;
  localparam logic [FUNC_W-1:0] FN_EQ  = 4'd4;
  localparam logic [FUNC_W-1:0] FN_NE  = 4'd5;
  localparam logic [FUNC_W-1:0] FN_LT  = 4'd6;
  localparam logic [FUNC_W-1:0] FN_GT  = 4'd7;
  localparam logic [FUNC_W-1:0] FN_LE  = 4'd8;
  localparam logic [FUNC_W-1:0] FN_GE  = 4'd9;

  typedef enum logic [1:0] {
    KIND_ARITH,
    KIND_CMP,
    KIND_NONE
  } kind_e;

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    kind_e                kind;
    logic signed [OW-1:0] a_num;
    logic signed [OW-1:0] a_den;
    logic signed [OW-1:0] b_num;
    logic signed [OW-1:0] b_den;
  } item_t;

  typedef struct packed {
    logic           full;
    logic           empty;
    logic [QCW-1:0] count;
  } q_status_t;

endpackage

// File: sv/rau_front.sv
module rau_front (
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [rau_pkg::FUNC_W-1:0]     func_i,
  input  logic signed [rau_pkg::OW-1:0]  a_num_i,
  input  logic signed [rau_pkg::OW-1:0]  a_den_i,
  input  logic signed [rau_pkg::OW-1:0]  b_num_i,
  input  logic signed [rau_pkg::OW-1:0]  b_den_i,
  input  rau_pkg::q_status_t             q_stat_i,
  output logic                           push_o,
  output rau_pkg::item_t                 item_o
);

  rau_pkg::kind_e kind;

  always_comb begin
    priority if (func_i <= rau_pkg::FN_DIV) begin
      kind = rau_pkg::KIND_ARITH;
    end else if (func_i <= rau_pkg::FN_GE) begin
      kind = rau_pkg::KIND_CMP;
    end else begin
      kind = rau_pkg::KIND_NONE;
    end
  end

  assign in_stall_o   = q_stat_i.full;
  assign push_o       = in_valid_i && !q_stat_i.full;
  assign item_o.func  = func_i;
  assign item_o.kind  = kind;
  assign item_o.a_num = a_num_i;
  assign item_o.a_den = a_den_i;
  assign item_o.b_num = b_num_i;
  assign item_o.b_den = b_den_i;

endmodule

// File: sv/rau_queue.sv
module rau_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rau_pkg::item_t     item_i,
  input  logic               pop_i,
  output rau_pkg::item_t     item_o,
  output rau_pkg::q_status_t stat_o
);

  rau_pkg::item_t              mem_q [rau_pkg::QDEPTH];
  logic [rau_pkg::QAW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [rau_pkg::QCW-1:0]     cnt_q;
  logic                        do_push, do_pop;

  assign stat_o.full  = (cnt_q == rau_pkg::QCW'(rau_pkg::QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.count = cnt_q;
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign item_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: sv/rau_div.sv
module rau_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [rau_pkg::PW-1:0]  dividend_i,
  input  logic [rau_pkg::PW-1:0]  divisor_i,
  output logic                    done_o,
  output logic [rau_pkg::PW-1:0]  quot_o,
  output logic [rau_pkg::PW-1:0]  rem_o
);

  localparam int PW = rau_pkg::PW;
  localparam int CW = $clog2(PW + 1);

  logic [PW-1:0] q_q, r_q, dv_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [PW:0]   trial;
  logic          fits;

  // Restoring division, one quotient bit per cycle.
  assign trial = {r_q, q_q[PW-1]};
  assign fits  = (trial >= {1'b0, dv_q});

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q  <= dividend_i;
      r_q  <= '0;
      dv_q <= divisor_i;
    end else if (busy_q) begin
      q_q <= {q_q[PW-2:0], fits};
      r_q <= fits ? PW'(trial - {1'b0, dv_q}) : trial[PW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(PW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o  = r_q;

endmodule

// File: sv/rau_back.sv
module rau_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rau_pkg::item_t                      item_i,
  input  rau_pkg::q_status_t                  q_stat_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [rau_pkg::RES_NUM_W-1:0] res_num_o,
  output logic [rau_pkg::RES_DEN_W-1:0]       res_den_o,
  output logic                                cmp_true_o,
  output logic                                den_zero_fixed_o
);

  localparam int OW = rau_pkg::OW;
  localparam int PW = rau_pkg::PW;
  localparam int NW = rau_pkg::RES_NUM_W;
  localparam int DW = rau_pkg::RES_DEN_W;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_GCD   = 4'd1;
  localparam logic [3:0] ST_GW    = 4'd2;
  localparam logic [3:0] ST_QN    = 4'd3;
  localparam logic [3:0] ST_QD    = 4'd4;
  localparam logic [3:0] ST_STORE = 4'd5;
  localparam logic [3:0] ST_MUL   = 4'd6;
  localparam logic [3:0] ST_SEL   = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  localparam logic [1:0] PH_A   = 2'd0;
  localparam logic [1:0] PH_B   = 2'd1;
  localparam logic [1:0] PH_RES = 2'd2;

  logic [3:0]          state_q, state_d;
  logic [1:0]          phase_q, phase_d;
  rau_pkg::item_t      item_q, item_d;
  logic [PW-1:0]       n_q, n_d, d_q, d_d, x_q, x_d, y_q, y_d, g_q, g_d;
  logic                nneg_q, nneg_d, dneg_q, dneg_d, fixed_q, fixed_d;
  logic [OW-1:0]       an_q, an_d, ad_q, ad_d, bn_q, bn_d, bd_q, bd_d;
  logic                aneg_q, aneg_d, bneg_q, bneg_d;
  logic [1:0]          mcnt_q, mcnt_d;
  logic [PW-1:0]       m_q [4];
  logic [PW-1:0]       m_d [4];
  logic signed [NW-1:0] rnum_q, rnum_d;
  logic [DW-1:0]       rden_q, rden_d;
  logic                cmp_q, cmp_d, ovalid_q, ovalid_d;

  logic                div_start, div_done;
  logic [PW-1:0]       div_a, div_b, div_quot, div_rem;
  logic [OW-1:0]       mul_a, mul_b;
  logic [PW-1:0]       prod;
  logic                red_neg;
  logic [PW:0]         sx, sy, rnum_w;
  logic                lt_ab, lt_ba, eq, right_neg;
  logic [PW-1:0]       sum_mag;
  logic                sum_neg;

  rau_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  function automatic logic [OW-1:0] mag_of(input logic signed [OW-1:0] v);
    mag_of = v[OW-1] ? OW'(-v) : v;
  endfunction

  always_comb begin
    unique case (mcnt_q)
      2'd0: begin mul_a = an_q; mul_b = bd_q; end
      2'd1: begin mul_a = bn_q; mul_b = ad_q; end
      2'd2: begin mul_a = ad_q; mul_b = bd_q; end
      default: begin mul_a = an_q; mul_b = bn_q; end
    endcase
  end
  assign prod = PW'(mul_a) * PW'(mul_b);

  assign red_neg = (n_q != '0) && (nneg_q != dneg_q);
  assign rnum_w  = red_neg ? (PW + 1)'(-{1'b0, n_q}) : {1'b0, n_q};

  // Cross products: m_q[0] carries the left sign, m_q[1] the right sign.
  assign sx    = aneg_q ? (PW + 1)'(-{1'b0, m_q[0]}) : {1'b0, m_q[0]};
  assign sy    = bneg_q ? (PW + 1)'(-{1'b0, m_q[1]}) : {1'b0, m_q[1]};
  assign lt_ab = $signed(sx) < $signed(sy);
  assign lt_ba = $signed(sy) < $signed(sx);
  assign eq    = (an_q == bn_q) && (ad_q == bd_q) && (aneg_q == bneg_q);

  assign right_neg = (item_q.func == rau_pkg::FN_SUB && m_q[1] != '0) ? !bneg_q : bneg_q;
  always_comb begin
    if (aneg_q == right_neg) begin
      sum_mag = m_q[0] + m_q[1];
      sum_neg = aneg_q;
    end else if (m_q[0] >= m_q[1]) begin
      sum_mag = m_q[0] - m_q[1];
      sum_neg = aneg_q;
    end else begin
      sum_mag = m_q[1] - m_q[0];
      sum_neg = right_neg;
    end
  end

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    item_d   = item_q;
    n_d = n_q; d_d = d_q; x_d = x_q; y_d = y_q; g_d = g_q;
    nneg_d = nneg_q; dneg_d = dneg_q; fixed_d = fixed_q;
    an_d = an_q; ad_d = ad_q; bn_d = bn_q; bd_d = bd_q;
    aneg_d = aneg_q; bneg_d = bneg_q;
    mcnt_d = mcnt_q;
    m_d = m_q;
    rnum_d = rnum_q; rden_d = rden_q; cmp_d = cmp_q; ovalid_d = ovalid_q;
    div_start = 1'b0;
    div_a     = x_q;
    div_b     = y_q;
    pop_o     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o   = 1'b1;
          item_d  = item_i;
          phase_d = PH_A;
          n_d     = PW'(mag_of(item_i.a_num));
          nneg_d  = item_i.a_num[OW-1];
          fixed_d = (item_i.a_den == '0);
          d_d     = (item_i.a_den == '0) ? PW'(1) : PW'(mag_of(item_i.a_den));
          dneg_d  = item_i.a_den[OW-1];
          x_d     = PW'(mag_of(item_i.a_num));
          y_d     = (item_i.a_den == '0) ? PW'(1) : PW'(mag_of(item_i.a_den));
          state_d = ST_GCD;
        end
      end
      ST_GCD: begin
        div_start = 1'b1;
        if (y_q == '0) begin
          g_d     = x_q;
          div_a   = n_q;
          div_b   = x_q;
          state_d = ST_QN;
        end else begin
          state_d = ST_GW;
        end
      end
      ST_GW: begin
        if (div_done) begin
          x_d     = y_q;
          y_d     = div_rem;
          state_d = ST_GCD;
        end
      end
      ST_QN: begin
        if (div_done) begin
          n_d       = div_quot;
          div_start = 1'b1;
          div_a     = d_q;
          div_b     = g_q;
          state_d   = ST_QD;
        end
      end
      ST_QD: begin
        if (div_done) begin
          d_d     = div_quot;
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        unique case (phase_q)
          PH_A: begin
            an_d    = n_q[OW-1:0];
            ad_d    = d_q[OW-1:0];
            aneg_d  = red_neg;
            phase_d = PH_B;
            n_d     = PW'(mag_of(item_q.b_num));
            nneg_d  = item_q.b_num[OW-1];
            if (item_q.b_den == '0) begin
              fixed_d = 1'b1;
            end
            d_d     = (item_q.b_den == '0) ? PW'(1) : PW'(mag_of(item_q.b_den));
            dneg_d  = item_q.b_den[OW-1];
            x_d     = PW'(mag_of(item_q.b_num));
            y_d     = (item_q.b_den == '0) ? PW'(1) : PW'(mag_of(item_q.b_den));
            state_d = ST_GCD;
          end
          PH_B: begin
            bn_d    = n_q[OW-1:0];
            bd_d    = d_q[OW-1:0];
            bneg_d  = red_neg;
            mcnt_d  = 2'd0;
            state_d = ST_MUL;
          end
          default: begin
            rnum_d   = NW'(rnum_w);
            rden_d   = DW'(d_q);
            cmp_d    = 1'b0;
            ovalid_d = 1'b1;
            state_d  = ST_OUT;
          end
        endcase
      end
      ST_MUL: begin
        m_d[mcnt_q] = prod;
        mcnt_d      = mcnt_q + 1'b1;
        if (mcnt_q == 2'd3) begin
          state_d = ST_SEL;
        end
      end
      ST_SEL: begin
        if (item_q.kind == rau_pkg::KIND_ARITH) begin
          unique case (item_q.func)
            rau_pkg::FN_MUL: begin
              n_d = m_q[3]; nneg_d = aneg_q ^ bneg_q;
              d_d = m_q[2]; dneg_d = 1'b0;
            end
            rau_pkg::FN_DIV: begin
              n_d = m_q[0]; nneg_d = aneg_q;
              d_d = m_q[1]; dneg_d = bneg_q;
            end
            default: begin
              n_d = sum_mag; nneg_d = sum_neg;
              d_d = m_q[2]; dneg_d = 1'b0;
            end
          endcase
          x_d = n_d;
          y_d = d_d;
          // A zero divisor leaves a zero denominator, which is forced to one.
          if (d_d == '0) begin
            d_d     = PW'(1);
            y_d     = PW'(1);
            dneg_d  = 1'b0;
            fixed_d = 1'b1;
          end
          phase_d = PH_RES;
          state_d = ST_GCD;
        end else begin
          unique case (item_q.func)
            rau_pkg::FN_EQ: cmp_d = eq;
            rau_pkg::FN_NE: cmp_d = !eq;
            rau_pkg::FN_LT: cmp_d = lt_ab;
            rau_pkg::FN_GT: cmp_d = lt_ba;
            rau_pkg::FN_LE: cmp_d = !lt_ba;
            rau_pkg::FN_GE: cmp_d = !lt_ab;
            default:        cmp_d = 1'b0;
          endcase
          rnum_d   = '0;
          rden_d   = DW'(1);
          ovalid_d = 1'b1;
          state_d  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          ovalid_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    n_q <= n_d; d_q <= d_d; x_q <= x_d; y_q <= y_d; g_q <= g_d;
    nneg_q <= nneg_d; dneg_q <= dneg_d; fixed_q <= fixed_d;
    an_q <= an_d; ad_q <= ad_d; bn_q <= bn_d; bd_q <= bd_d;
    aneg_q <= aneg_d; bneg_q <= bneg_d;
    mcnt_q <= mcnt_d;
    m_q <= m_d;
    rnum_q <= rnum_d; rden_q <= rden_d; cmp_q <= cmp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      phase_q  <= PH_A;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o      = ovalid_q;
  assign res_num_o        = rnum_q;
  assign res_den_o        = rden_q;
  assign cmp_true_o       = cmp_q;
  assign den_zero_fixed_o = fixed_q;

endmodule

// File: sv/rational_arith_unit.sv
// Rational arithmetic unit: each beat carries two raw fractions and an operation code.
// Both operands are reduced by their Euclid GCD (a zero denominator counts as one and
// sets den_zero_fixed), then add, sub, mul and div form cross products that are reduced
// the same way, while the six comparisons return one bit with a result of 0/1. A
// two-entry queue takes beats while the engine works, so the input stalls only when
// the queue is full. Every operand and result reduction runs Euclid steps on a shared
// bit-serial divider that takes 32 quotient steps, one division per Euclid step, and
// each reduction ends with two divisions by the GCD. The cross products are then
// formed one after another, followed by a selection step. The result waits in the
// output register until taken.
`include "rational_arith_unit_defines.svh"

module rational_arith_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [rau_pkg::FUNC_W-1:0]           func_i,
  input  logic signed [rau_pkg::OW-1:0]        a_num_i,
  input  logic signed [rau_pkg::OW-1:0]        a_den_i,
  input  logic signed [rau_pkg::OW-1:0]        b_num_i,
  input  logic signed [rau_pkg::OW-1:0]        b_den_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [rau_pkg::RES_NUM_W-1:0] res_num_o,
  output logic [rau_pkg::RES_DEN_W-1:0]        res_den_o,
  output logic                                 cmp_true_o,
  output logic                                 den_zero_fixed_o
);

  rau_pkg::q_status_t q_stat;
  rau_pkg::item_t     push_item, head_item;
  logic               q_push, q_pop;

  rau_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .a_num_i    (a_num_i),
    .a_den_i    (a_den_i),
    .b_num_i    (b_num_i),
    .b_den_i    (b_den_i),
    .q_stat_i   (q_stat),
    .push_o     (q_push),
    .item_o     (push_item)
  );

  rau_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (push_item),
    .pop_i  (q_pop),
    .item_o (head_item),
    .stat_o (q_stat)
  );

  rau_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_i           (head_item),
    .q_stat_i         (q_stat),
    .pop_o            (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .res_num_o        (res_num_o),
    .res_den_o        (res_den_o),
    .cmp_true_o       (cmp_true_o),
    .den_zero_fixed_o (den_zero_fixed_o)
  );

  `RAU_ASSERT_IMP(a_den_positive, out_valid_o, res_den_o != '0)
  `RAU_ASSERT_IMP(a_cmp_shape, out_valid_o && cmp_true_o, res_num_o == '0 && res_den_o == rau_pkg::RES_DEN_W'(1))
  `RAU_ASSERT_IMP(a_stall_full, 1'b1, in_stall_o == q_stat.full)
  `RAU_ASSERT_NXT(a_push_count, q_push && !q_pop, q_stat.count == $past(q_stat.count) + 1'b1)

endmodule
